FILE: rtl/bcde_pkg.sv
package bcde_pkg;

   // default coordinate width
   localparam int CoordWidthDefault = 16;
   // result field width
   localparam int DistWidth = 17;

   // control bits that follow a request down the pipeline
   typedef struct packed {
      logic valid;
   } lane_ctl_type;

endpackage

FILE: rtl/bcde_lane.sv
module bcde_lane #(
   parameter int COORD_WIDTH = bcde_pkg::CoordWidthDefault
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] a_low,
   input  logic signed [COORD_WIDTH-1:0] a_high,
   input  logic signed [COORD_WIDTH-1:0] b_low,
   input  logic signed [COORD_WIDTH-1:0] b_high,
   output logic [2*COORD_WIDTH-1:0]      sq_min,
   output logic [2*COORD_WIDTH-1:0]      sq_max
);
   import bcde_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int SQW = 2 * COORD_WIDTH;

   logic [DW-1:0] d0, d1, d2, d3, lo01, hi01, lo23, hi23;
   logic [DW-1:0] dmin_in, dmax_in, dmin_ff, dmax_ff;
   logic [2*COORD_WIDTH-1:0] sq_min_ff, sq_max_ff;

   function automatic logic [DW-1:0] absd(input logic signed [COORD_WIDTH-1:0] p,
                                          input logic signed [COORD_WIDTH-1:0] q);
      logic signed [DW-1:0] d;
      d = DW'(p) - DW'(q);
      return d[DW-1] ? DW'(-d) : DW'(d);
   endfunction

   // four pairings and their extremes
   always_comb begin
      d0 = absd(a_low, b_low);
      d1 = absd(a_low, b_high);
      d2 = absd(a_high, b_low);
      d3 = absd(a_high, b_high);
      lo01 = (d1 < d0) ? d1 : d0;
      hi01 = (d1 > d0) ? d1 : d0;
      lo23 = (d3 < d2) ? d3 : d2;
      hi23 = (d3 > d2) ? d3 : d2;
      dmin_in = (lo23 < lo01) ? lo23 : lo01;
      dmax_in = (hi23 > hi01) ? hi23 : hi01;
   end

   // difference stage then square stage
   always_ff @(posedge clock) begin
      dmin_ff   <= dmin_in;
      dmax_ff   <= dmax_in;
      sq_min_ff <= SQW'(dmin_ff) * SQW'(dmin_ff);
      sq_max_ff <= SQW'(dmax_ff) * SQW'(dmax_ff);
   end

   assign sq_min = sq_min_ff;
   assign sq_max = sq_max_ff;
endmodule

FILE: rtl/bcde_sqrt.sv
module bcde_sqrt #(
   parameter int SW = 2 * bcde_pkg::CoordWidthDefault + 2,
   parameter int RW = bcde_pkg::DistWidth
) (
   input  logic          clock,
   input  logic [SW-1:0] radicand,
   output logic [RW-1:0] root
);
   import bcde_pkg::*;

   // one result bit per stage, restoring form on the remainder
   logic [SW-1:0] rem_ff  [1:RW];
   logic [RW-1:0] root_ff [1:RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int B = RW - 1 - s;
      logic [SW+1:0] trial;
      logic [SW+1:0] rem_w;
      logic [SW-1:0] rem_cur;
      logic [SW-1:0] rem_in;
      logic [RW-1:0] root_cur;
      logic [RW-1:0] root_in;
      // stage input: the radicand or the previous stage
      if (s == 0) begin : g_first
         assign rem_cur  = radicand;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[s];
         assign root_cur = root_ff[s];
      end
      always_comb begin
         // (r+2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
         trial = ((SW+2)'(root_cur) << (B + 1)) + ((SW+2)'(1) << (2 * B));
         rem_w = (SW+2)'(rem_cur);
         if (trial <= rem_w) begin
            rem_in  = SW'(rem_w - trial);
            root_in = root_cur | (RW'(1) << B);
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= rem_in;
         root_ff[s+1] <= root_in;
      end
   end

   assign root = root_ff[RW];
endmodule

FILE: rtl/box_corner_distance_extremes.sv
// box_corner_distance_extremes
// Takes a pair of axis-aligned boxes (low and high corner each) on the req_
// ports, qualified by start, and returns the floor of the smallest and the
// largest corner-to-corner distance on the rsp_ ports, marked by rsp_valid.
// One lane per axis finds the extreme absolute differences and squares them;
// a merge stage sums the three axes and two pipelined square-root units, one
// result bit per stage, finish the job.
// Each request passes the difference and square registers of a lane, the merge
// register and the root pipeline, whose depth is set by the root width.
// Throughput: one request per cycle; busy is always low.
// The result is shown for one cycle only; the receiver cannot stall, so the
// pipeline never stops.
// Reset clears the valid pipeline; data registers are not reset.
// For coordinates wider than 16 bits the roots wrap to 17 bits.
module box_corner_distance_extremes #(
   parameter int COORD_WIDTH = bcde_pkg::CoordWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_low_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_low_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_low_z,
   input  logic signed [COORD_WIDTH-1:0] req_a_high_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_high_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_high_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_low_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_low_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_low_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_high_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_high_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_high_z,
   output logic                          rsp_valid,
   output logic [bcde_pkg::DistWidth-1:0] rsp_nearest_corner_distance,
   output logic [bcde_pkg::DistWidth-1:0] rsp_farthest_corner_distance
);
   import bcde_pkg::*;

   localparam int SQW = 2 * COORD_WIDTH;
   localparam int SW  = SQW + 2;
   localparam int RW  = (SW + 1) / 2;
   localparam int LAT = 3 + RW;

   logic [SQW-1:0] mn_x, mx_x, mn_y, mx_y, mn_z, mx_z;
   logic [SW-1:0]  near_sq_ff, far_sq_ff;
   logic [RW-1:0]  near_root, far_root;
   lane_ctl_type   ctl_ff [LAT];
   lane_ctl_type   ctl_in;

   assign busy = 1'b0;

   // one lane per axis
   bcde_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
      .clock(clock), .a_low(req_a_low_x), .a_high(req_a_high_x),
      .b_low(req_b_low_x), .b_high(req_b_high_x), .sq_min(mn_x), .sq_max(mx_x));
   bcde_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
      .clock(clock), .a_low(req_a_low_y), .a_high(req_a_high_y),
      .b_low(req_b_low_y), .b_high(req_b_high_y), .sq_min(mn_y), .sq_max(mx_y));
   bcde_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
      .clock(clock), .a_low(req_a_low_z), .a_high(req_a_high_z),
      .b_low(req_b_low_z), .b_high(req_b_high_z), .sq_min(mn_z), .sq_max(mx_z));

   // merge the lanes
   always_ff @(posedge clock) begin
      near_sq_ff <= SW'(mn_x) + SW'(mn_y) + SW'(mn_z);
      far_sq_ff  <= SW'(mx_x) + SW'(mx_y) + SW'(mx_z);
   end

   bcde_sqrt #(.SW(SW), .RW(RW)) u_sqrt_near (
      .clock(clock), .radicand(near_sq_ff), .root(near_root));
   bcde_sqrt #(.SW(SW), .RW(RW)) u_sqrt_far (
      .clock(clock), .radicand(far_sq_ff), .root(far_root));

   // valid pipeline
   assign ctl_in.valid = start;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) ctl_ff[i] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < LAT; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   assign rsp_valid = ctl_ff[LAT-1].valid;
   assign rsp_nearest_corner_distance  = DistWidth'(near_root);
   assign rsp_farthest_corner_distance = DistWidth'(far_root);

   // nearest never exceeds farthest while coordinates are at most 16 bits wide
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nearest_corner_distance <= rsp_farthest_corner_distance
         || COORD_WIDTH > 16)
      else $error("nearest above farthest");
   // a registered request shows up on rsp_valid at the end of the valid pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[0].valid |-> ##(LAT-1) rsp_valid)
      else $error("response lost");
   // never busy
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy asserted");
endmodule
